>>> sv/rgp_pkg.sv
// Package for the radial gradient projection block: field widths, register
// indexes and the structs passed between the front end and the cell chain.
// Used by every module of the block; depends on nothing.
package rgp_pkg;

    localparam int COORD_BITS = 12;
    localparam int GRAD_BITS  = 16;
    localparam int OUT_W      = 33;
    localparam int REF_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int PX_W   = COORD_BITS + 4;
    localparam int D_W    = ((PX_W > REF_W) ? PX_W : REF_W) + 1;
    localparam int PROD_W = GRAD_BITS + D_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int A_W    = NUM_W;
    localparam int A_L    = A_W / 2;
    localparam int A_H    = A_W - A_L;
    localparam int S_W    = 2 * D_W;
    localparam int R_W    = 2 * A_W + 2;
    localparam int M_W    = GRAD_BITS + 1;
    localparam int XR_W   = S_W + 2 * M_W + 2;
    localparam int X_W    = ((R_W > XR_W) ? R_W : XR_W) + 2;
    localparam int SQ_W   = ((2 * M_W > OUT_W) ? 2 * M_W : OUT_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_REF_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG    = 3'd4;

    typedef struct packed {
        logic [REF_W-1:0] ref_x;
        logic [REF_W-1:0] ref_y;
        logic             tangential;
        logic             square;
        logic             magnitude;
    } t_cfg;

    // Running state of the rounding search, handed from cell to cell.
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] ys;
        logic signed [X_W-1:0] ss;
        logic [R_W-1:0]        r;
        logic [M_W-1:0]        m;
        logic                  neg;
        logic                  zero;
    } t_cell;

endpackage

>>> sv/rgp_front.sv
// Front end of the radial gradient projection: offsets, products, numerator
// and squared norms, four registered stages. Depends on rgp_pkg.
module rgp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgp_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rgp_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  logic [rgp_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  logic signed [rgp_pkg::GRAD_BITS-1:0] i_gradient_x,
    input  logic signed [rgp_pkg::GRAD_BITS-1:0] i_gradient_y,
    output logic                                o_valid,
    output rgp_pkg::t_cell                      o_data,
    input  logic                                i_ready
);
    localparam int D_W    = rgp_pkg::D_W;
    localparam int PROD_W = rgp_pkg::PROD_W;
    localparam int NUM_W  = rgp_pkg::NUM_W;
    localparam int A_W    = rgp_pkg::A_W;
    localparam int A_L    = rgp_pkg::A_L;
    localparam int A_H    = rgp_pkg::A_H;
    localparam int S_W    = rgp_pkg::S_W;
    localparam int R_W    = rgp_pkg::R_W;
    localparam int X_W    = rgp_pkg::X_W;
    localparam int M_W    = rgp_pkg::M_W;

    logic                     r1_v, r2_v, r3_v, r4_v;
    logic                     rdy1, rdy2, rdy3, rdy4;
    logic signed [PROD_W-1:0] r1_p1, r1_p2;
    logic [S_W-1:0]           r1_sx, r1_sy;
    logic signed [NUM_W-1:0]  r2_num;
    logic [S_W-1:0]           r2_s;
    logic [2*A_H-1:0]         r3_hh;
    logic [A_H+A_L-1:0]       r3_hl;
    logic [2*A_L-1:0]         r3_ll;
    logic [S_W-1:0]           r3_s;
    logic                     r3_neg;
    rgp_pkg::t_cell           r4_d;

    logic signed [D_W-1:0]    dx, dy;
    logic signed [PROD_W-1:0] p1, p2;
    logic signed [S_W-1:0]    sx, sy;
    logic signed [NUM_W-1:0]  num;
    logic [A_W-1:0]           a_mag;
    logic [A_H-1:0]           a_hi;
    logic [A_L-1:0]           a_lo;
    logic [R_W-1:0]           r_sum;
    logic signed [X_W-1:0]    s_ext;

    assign rdy4    = !r4_v || i_ready;
    assign rdy3    = !r3_v || rdy4;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r4_v;
    assign o_data  = r4_d;

    // Pixel positions become Q.4 so that they line up with the reference point.
    assign dx = $signed(D_W'({i_pixel_x, 4'b0000})) - $signed(D_W'(i_cfg.ref_x));
    assign dy = $signed(D_W'({i_pixel_y, 4'b0000})) - $signed(D_W'(i_cfg.ref_y));
    assign p1 = i_cfg.tangential ? i_gradient_x * dy : i_gradient_x * dx;
    assign p2 = i_cfg.tangential ? i_gradient_y * dx : i_gradient_y * dy;
    assign sx = dx * dx;
    assign sy = dy * dy;

    assign num   = i_cfg.tangential ? NUM_W'(r1_p1) - NUM_W'(r1_p2)
                                    : NUM_W'(r1_p1) + NUM_W'(r1_p2);
    assign a_mag = r2_num[NUM_W-1] ? A_W'(-r2_num) : A_W'(r2_num);
    assign a_hi  = a_mag[A_W-1:A_L];
    assign a_lo  = a_mag[A_L-1:0];

    // Four times the squared numerator, assembled from three partial products.
    assign r_sum = ((R_W'(r3_hh) << (2 * A_L)) + (R_W'(r3_hl) << (A_L + 1))
                    + R_W'(r3_ll)) << 2;
    assign s_ext = $signed(X_W'(r3_s));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_p1 <= p1;
            r1_p2 <= p2;
            r1_sx <= S_W'(sx);
            r1_sy <= S_W'(sy);
        end
        if (rdy2) begin
            r2_num <= num;
            r2_s   <= r1_sx + r1_sy;
        end
        if (rdy3) begin
            r3_hh  <= a_hi * a_hi;
            r3_hl  <= a_hi * a_lo;
            r3_ll  <= a_lo * a_lo;
            r3_s   <= r2_s;
            r3_neg <= r2_num[NUM_W-1];
        end
        if (rdy4) begin
            // Seed the search at the top bit: odd factor -1, so X starts at S.
            r4_d.x    <= s_ext;
            r4_d.ys   <= -(s_ext <<< (M_W + 1));
            r4_d.ss   <= s_ext <<< (2 * M_W);
            r4_d.r    <= r_sum;
            r4_d.m    <= '0;
            r4_d.neg  <= r3_neg;
            r4_d.zero <= (r3_s == '0);
        end
    end

endmodule

>>> sv/rgp_cell.sv
// One cell of the rounding search: decides one bit of the rounded quotient
// and rescales the running terms for the next lower bit. Depends on rgp_pkg.
module rgp_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rgp_pkg::t_cell i_data,
    output logic           o_valid,
    output rgp_pkg::t_cell o_data,
    input  logic           i_ready
);
    localparam int X_W = rgp_pkg::X_W;
    localparam int M_W = rgp_pkg::M_W;

    logic                  r_v;
    rgp_pkg::t_cell        r_d;
    logic signed [X_W-1:0] xc;
    logic signed [X_W-1:0] ys_acc;
    logic                  take;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // Trying the bit adds the cross term and the square of the new bit.
    assign xc     = i_data.x + i_data.ys + i_data.ss;
    assign take   = (xc <= $signed(X_W'(i_data.r)));
    assign ys_acc = take ? i_data.ys + (i_data.ss <<< 1) : i_data.ys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_d.x    <= take ? xc : i_data.x;
            r_d.ys   <= ys_acc >>> 1;
            r_d.ss   <= i_data.ss >>> 2;
            r_d.r    <= i_data.r;
            r_d.m    <= {i_data.m[M_W-2:0], take};
            r_d.neg  <= i_data.neg;
            r_d.zero <= i_data.zero;
        end
    end

endmodule

>>> sv/radial_gradient_projection.sv
// Radial or tangential gradient projection onto the direction from a reference point.
// The pipeline has four front stages, one cell per quotient bit and one output stage.
// Throughput, set by the cell chain, is one pixel per cycle while i_stall is low;
// bubbles collapse, so the input keeps taking pixels while one waits.
// Synchronous active-low reset clears all valid flags and the configuration registers.
// Depends on rgp_pkg, rgp_front and rgp_cell.
module radial_gradient_projection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rgp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rgp_pkg::REF_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [rgp_pkg::COORD_BITS-1:0]       i_pixel_x,
    input  logic [rgp_pkg::COORD_BITS-1:0]       i_pixel_y,
    input  logic signed [rgp_pkg::GRAD_BITS-1:0] i_gradient_x,
    input  logic signed [rgp_pkg::GRAD_BITS-1:0] i_gradient_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rgp_pkg::OUT_W-1:0]     o_projected_value
);
    localparam int M_W   = rgp_pkg::M_W;
    localparam int OUT_W = rgp_pkg::OUT_W;
    localparam int SQ_W  = rgp_pkg::SQ_W;

    rgp_pkg::t_cfg   r_cfg;
    logic            front_ready;
    logic            chain_v   [0:M_W];
    logic            chain_rdy [0:M_W];
    rgp_pkg::t_cell  chain_d   [0:M_W];
    logic            r_out_v;
    logic [OUT_W-1:0] r_out;
    logic            out_rdy;
    logic [SQ_W-1:0] m_ext;
    logic [SQ_W-1:0] res;
    rgp_pkg::t_cell  fin;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rgp_pkg::REG_REF_X:  r_cfg.ref_x      <= i_cfg_data;
                rgp_pkg::REG_REF_Y:  r_cfg.ref_y      <= i_cfg_data;
                rgp_pkg::REG_SELECT: r_cfg.tangential <= i_cfg_data[0];
                rgp_pkg::REG_SQUARE: r_cfg.square     <= i_cfg_data[0];
                rgp_pkg::REG_MAG:    r_cfg.magnitude  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rgp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (front_ready),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_gradient_x (i_gradient_x),
        .i_gradient_y (i_gradient_y),
        .o_valid      (chain_v[0]),
        .o_data       (chain_d[0]),
        .i_ready      (chain_rdy[0])
    );

    for (genvar g = 0; g < M_W; g++) begin : g_cell
        rgp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_v[g]),
            .o_ready (chain_rdy[g]),
            .i_data  (chain_d[g]),
            .o_valid (chain_v[g+1]),
            .o_data  (chain_d[g+1]),
            .i_ready (chain_rdy[g+1])
        );
    end

    assign out_rdy       = !r_out_v || !i_stall;
    assign chain_rdy[M_W] = out_rdy;
    assign fin           = chain_d[M_W];
    assign m_ext         = fin.zero ? '0 : SQ_W'(fin.m);

    always_comb begin
        if (r_cfg.square) begin
            res = m_ext * m_ext;
        end else if (r_cfg.magnitude || !fin.neg) begin
            res = m_ext;
        end else begin
            res = -m_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= chain_v[M_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out <= res[OUT_W-1:0];
        end
    end

    assign o_valid           = r_out_v;
    assign o_projected_value = $signed(r_out);

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for radial_gradient_projection: a directed table, then
// randomized phases, checked by an in-bench projection predictor or fixed values.
// Depends on rgp_pkg and the radial_gradient_projection RTL.
module tb;
    localparam int COORD_BITS = rgp_pkg::COORD_BITS;
    localparam int GRAD_BITS  = rgp_pkg::GRAD_BITS;
    localparam int OUT_W      = rgp_pkg::OUT_W;
    localparam int REF_W      = rgp_pkg::REF_W;
    localparam int CFG_IDX_W  = rgp_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_REF_X  = rgp_pkg::REG_REF_X;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y  = rgp_pkg::REG_REF_Y;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT = rgp_pkg::REG_SELECT;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE = rgp_pkg::REG_SQUARE;
    localparam logic [CFG_IDX_W-1:0] REG_MAG    = rgp_pkg::REG_MAG;

    localparam int LATENCY   = 4 + GRAD_BITS + 2;
    localparam int IDLE_MAX  = 3000;
    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 128;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [REF_W-1:0]             i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [COORD_BITS-1:0]        i_pixel_x = '0;
    logic [COORD_BITS-1:0]        i_pixel_y = '0;
    logic signed [GRAD_BITS-1:0]  i_gradient_x = '0;
    logic signed [GRAD_BITS-1:0]  i_gradient_y = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic signed [OUT_W-1:0]      o_projected_value;

    radial_gradient_projection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_gradient_x(i_gradient_x), .i_gradient_y(i_gradient_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_projected_value(o_projected_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [REF_W-1:0] sh_ref_x = '0;
    logic [REF_W-1:0] sh_ref_y = '0;
    logic             sh_tangential = 1'b0;
    logic             sh_square = 1'b0;
    logic             sh_magnitude = 1'b0;

    logic [OUT_W-1:0] projection_q[$];
    logic             row_fixed = 1'b0;
    logic [OUT_W-1:0] row_value = '0;
    int               errors = 0;
    int               n_in = 0;
    int               n_out = 0;
    int               n_cfg = 0;
    int               idle_cycles = 0;
    int               burst_left = 0;

    function automatic logic [OUT_W-1:0] predict_projection(
        logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
        logic signed [GRAD_BITS-1:0] gx, logic signed [GRAD_BITS-1:0] gy);
        longint dx, dy, num, s, a, k;
        logic [127:0] lhs, rhs;
        longint m, t, res;
        dx = longint'({px, 4'b0}) - longint'(sh_ref_x);
        dy = longint'({py, 4'b0}) - longint'(sh_ref_y);
        if (sh_tangential)
            num = longint'(gx) * dy - longint'(gy) * dx;
        else
            num = longint'(gx) * dx + longint'(gy) * dy;
        s = dx * dx + dy * dy;
        a = (num < 0) ? -num : num;
        m = 0;
        if (s != 0) begin
            for (int b = GRAD_BITS; b >= 0; b--) begin
                t = m | (longint'(1) << b);
                k = 2 * t - 1;
                lhs = 128'(k) * 128'(k) * 128'(s);
                rhs = 128'(2 * a) * 128'(2 * a);
                if (lhs <= rhs)
                    m = t;
            end
        end
        if (sh_square)
            res = m * m;
        else if (sh_magnitude || num >= 0)
            res = m;
        else
            res = -m;
        return res[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Input and output monitors, plus the watchdog on accepted transfers.
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (i_valid && !o_stall) begin
                projection_q.push_back(row_fixed ? row_value :
                    predict_projection(i_pixel_x, i_pixel_y, i_gradient_x, i_gradient_y));
                n_in++;
                idle_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready)
                idle_cycles = 0;
            if (o_valid && !i_stall) begin
                idle_cycles = 0;
                n_out++;
                if (projection_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d",
                                              o_projected_value));
                end else begin
                    want = projection_q.pop_front();
                    if (o_projected_value !== want)
                        report_mismatch($sformatf("projected_value got %0d want %0d",
                                                  o_projected_value, $signed(want)));
                end
            end
            if (idle_cycles >= IDLE_MAX) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls in modes that change every so often: never, at random,
    // or in long runs.
    int         stall_count = 0;
    int         stall_hold = 0;
    logic [1:0] stall_mode = 2'd0;
    logic       stall_level = 1'b0;
    always @(posedge i_clk) begin
        stall_count++;
        if (stall_count % 97 == 0)
            stall_mode = 2'($urandom_range(0, 2));
        case (stall_mode)
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_hold == 0) begin
                    stall_level = ~stall_level;
                    stall_hold = $urandom_range(1, 20);
                end
                stall_hold--;
                i_stall <= stall_level;
            end
        endcase
    end

    // Leaves valid high so that writes can follow each other; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg++;
        case (idx)
            REG_REF_X:  sh_ref_x = val;
            REG_REF_Y:  sh_ref_y = val;
            REG_SELECT: sh_tangential = val[0];
            REG_SQUARE: sh_square = val[0];
            REG_MAG:    sh_magnitude = val[0];
            default: ;
        endcase
    endtask

    // Stop sending and wait until every expected result is back, then let the
    // pipeline settle.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (projection_q.size() != 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [REF_W-1:0] rx, input logic [REF_W-1:0] ry,
                             input logic sel, input logic sq, input logic mag);
        drain();
        write_reg(REG_REF_X, rx);
        write_reg(REG_REF_Y, ry);
        write_reg(REG_SELECT, {15'($urandom), sel});
        write_reg(REG_SQUARE, {15'($urandom), sq});
        write_reg(REG_MAG, {15'($urandom), mag});
        // An index past the register list must be ignored.
        write_reg(3'($urandom_range(5, 7)), 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                              input logic signed [GRAD_BITS-1:0] gx,
                              input logic signed [GRAD_BITS-1:0] gy,
                              input logic fixed, input logic [OUT_W-1:0] fixed_val);
        int gap;
        i_valid      <= 1'b1;
        i_pixel_x    <= px;
        i_pixel_y    <= py;
        i_gradient_x <= gx;
        i_gradient_y <= gy;
        row_fixed    <= fixed;
        row_value    <= fixed_val;
        do @(posedge i_clk); while (o_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    typedef struct {
        logic [REF_W-1:0]            rx, ry;
        logic                        sel, sq, mag;
        logic [COORD_BITS-1:0]       px, py;
        logic signed [GRAD_BITS-1:0] gx, gy;
        logic                        fixed;
        logic [OUT_W-1:0]            val;
    } t_row;

    t_row directed [0:21] = '{
        '{0, 0, 0, 0, 0, 0, 0, 1234, -5, 1, 0},
        '{0, 0, 0, 0, 0, 1, 0, 100, -77, 1, 100},
        '{0, 0, 0, 0, 0, 0, 1, 5, -32768, 1, -33'sd32768},
        '{0, 0, 0, 0, 0, 1, 0, 32767, 0, 1, 32767},
        '{0, 0, 0, 0, 0, 4095, 4095, -32768, -32768, 0, 0},
        '{0, 0, 0, 0, 0, 4095, 0, 32767, 32767, 0, 0},
        '{0, 0, 0, 0, 0, 0, 4095, -1, 1, 0, 0},
        '{0, 0, 0, 0, 0, 3, 4, 3, 4, 1, 5},
        '{0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0},
        '{0, 0, 1, 0, 0, 1, 0, 0, 7, 1, -33'sd7},
        '{0, 0, 1, 0, 0, 0, 1, 9, 0, 1, 9},
        '{0, 0, 1, 0, 0, 4095, 2048, -32768, 32767, 0, 0},
        '{0, 0, 1, 0, 1, 1, 0, 0, 7, 1, 7},
        '{0, 0, 0, 1, 1, 1, 0, -32768, 0, 1, 33'd1073741824},
        '{0, 0, 0, 1, 1, 4095, 4095, 32767, 32767, 0, 0},
        '{0, 0, 0, 1, 1, 0, 0, 32767, -32768, 1, 0},
        '{65535, 65535, 0, 0, 0, 4095, 4095, 32767, -32768, 0, 0},
        '{65535, 65535, 0, 0, 0, 0, 0, 32767, 32767, 0, 0},
        '{16, 32, 0, 0, 0, 1, 2, -32768, 32767, 1, 0},
        '{16, 32, 0, 0, 0, 2, 2, -3, 0, 1, -33'sd3},
        '{24, 0, 0, 0, 0, 1, 0, 5, 0, 1, -33'sd5},
        '{0, 0, 0, 0, 1, 1, 0, -9, 3, 1, 9}
    };

    initial begin
        logic [REF_W-1:0]            rx, ry;
        logic [COORD_BITS-1:0]       px, py;
        logic signed [GRAD_BITS-1:0] gx, gy;
        int                          pick;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].rx != sh_ref_x || directed[i].ry != sh_ref_y ||
                directed[i].sel != sh_tangential || directed[i].sq != sh_square ||
                directed[i].mag != sh_magnitude)
                configure(directed[i].rx, directed[i].ry, directed[i].sel,
                          directed[i].sq, directed[i].mag);
            send_pixel(directed[i].px, directed[i].py, directed[i].gx, directed[i].gy,
                       directed[i].fixed, directed[i].val);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin rx = 16'd0; ry = 16'hFFFF; end
                1: begin rx = 16'hFFFF; ry = 16'd0; end
                2: begin rx = {12'($urandom), 4'd0}; ry = {12'($urandom), 4'd0}; end
                default: begin rx = 16'($urandom); ry = 16'($urandom); end
            endcase
            configure(rx, ry, ph[0], (ph % 3) == 2, ph[1]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                px = 12'($urandom);
                py = 12'($urandom);
                gx = 16'($urandom);
                gy = 16'($urandom);
                if (pick < 15) begin
                    // Pixels at or next to the reference point.
                    px = 12'((sh_ref_x >> 4) + $urandom_range(0, 2) - 1);
                    py = 12'((sh_ref_y >> 4) + $urandom_range(0, 2) - 1);
                end else if (pick < 30) begin
                    gx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    gy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                send_pixel(px, py, gx, gy, 1'b0, '0);
            end
        end

        drain();
        $display("Sent %0d pixels and checked %0d results over %0d register writes,",
                 n_in, n_out, n_cfg);
        $display("covering radial, tangential, magnitude and square modes at extreme references.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
